// ----- hw/rtl/gsc_pkg.sv -----
// ---------------------------------------------------------------------------
// gsc_pkg
// shared types and constants of the gsm 7-bit septet codec
// ---------------------------------------------------------------------------
package gsc_pkg;

    localparam int DATA_W  = 8;
    localparam int SEPT_W  = 7;
    localparam int BUF_W   = 16;
    localparam int HELD_W  = 9;
    localparam int CNT_W   = 8;
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    typedef enum logic {
        DIR_PACK   = 1'b0,
        DIR_UNPACK = 1'b1
    } t_dir;

    typedef enum logic {
        CFG_DIRECTION    = 1'b0,
        CFG_SEPTET_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              last;
        logic              shrt;
    } t_res;

    // one request worth of results, one or two of them
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r1;
        t_res       r0;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ----- hw/rtl/gsm7_septet_codec_unit.sv -----
// ---------------------------------------------------------------------------
// gsm7_septet_codec_unit
// streaming gsm 7-bit packer and unpacker
// ---------------------------------------------------------------------------
// input stream s_axis carries characters (pack) or octets (unpack), with
// tlast on the final item of a message. output stream m_axis carries
// octets or septets, tlast on the final result, tuser flagging an unpack
// message that ended before the septet count was reached.
// the config port writes direction (index 0, clears the accumulator) and
// septet count (index 1); write only while no message is in flight.
// each request yields zero, one or two results. the first result goes
// through the queue and the output register before it shows on m_axis.
// the front takes one request per cycle while the queue has room; the
// output register drains one result per cycle while m_axis is ready.
// a four-entry queue between front and back absorbs bursts; when m_axis
// stalls the queue fills and s_axis_tready drops. reset clears the control
// registers, accumulator and queue, leaving pack mode, septet count zero.
// ---------------------------------------------------------------------------
module gsm7_septet_codec_unit
    import gsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // data_in
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // data_out
    output logic              m_axis_tlast,
    output logic              m_axis_tuser    // short_input
);

    t_q_stat q_stat;
    t_entry  push_entry;
    t_entry  head;
    logic    push;
    logic    pop;

    gsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tlast     (s_axis_tlast),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    gsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    gsc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_tuser  (m_axis_tuser)
    );

endmodule

// ----- hw/rtl/gsc_front.sv -----
// ---------------------------------------------------------------------------
// gsc_front
// accepts requests, runs the bit accumulator and builds result entries
// ---------------------------------------------------------------------------
module gsc_front
    import gsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [CNT_W-1:0]  i_cfg_wdata,
    input  logic              i_tvalid,
    output logic              o_tready,
    input  logic [DATA_W-1:0] i_tdata,
    input  logic              i_tlast,
    input  t_q_stat           i_q_stat,
    output logic              o_push,
    output t_entry            o_entry
);

    t_dir               r_dir, n_dir;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [BUF_W-1:0]   r_buf, n_buf;
    logic [HELD_W-1:0]  r_held, n_held;
    logic [CNT_W-1:0]   r_done, n_done;

    logic               accept;

    logic [BUF_W-1:0]   p_tmp, p_buf1;
    logic [HELD_W-1:0]  p_hsum, p_held1;
    logic               p_e1, p_flush;

    logic [23:0]        u_tmp;
    logic [HELD_W-1:0]  u_hsum;
    logic [CNT_W:0]     u_d1, u_d2, u_cnt9, u_done_new;
    logic               u_act, u_e2, u_short;

    assign o_tready = !i_q_stat.full;
    assign accept   = i_tvalid && o_tready;

    // pack path
    always_comb begin
        p_tmp   = r_buf | (BUF_W'(i_tdata[SEPT_W-1:0]) << r_held[3:0]);
        p_hsum  = r_held + HELD_W'(SEPT_W);
        p_e1    = p_hsum >= HELD_W'(DATA_W);
        p_buf1  = p_e1 ? (p_tmp >> DATA_W) : p_tmp;
        p_held1 = p_e1 ? (p_hsum - HELD_W'(DATA_W)) : p_hsum;
        p_flush = i_tlast && (p_held1 != '0);
    end

    // unpack path
    always_comb begin
        u_tmp      = 24'(r_buf) | (24'(i_tdata) << r_held[3:0]);
        u_hsum     = r_held + HELD_W'(DATA_W);
        u_cnt9     = {1'b0, r_count};
        u_d1       = {1'b0, r_done} + (CNT_W+1)'(1);
        u_d2       = {1'b0, r_done} + (CNT_W+1)'(2);
        u_act      = r_done < r_count;
        u_e2       = (u_hsum >= HELD_W'(2 * SEPT_W)) && (u_d1 < u_cnt9);
        u_done_new = u_e2 ? u_d2 : u_d1;
        u_short    = i_tlast && (u_done_new < u_cnt9);
    end

    always_comb begin
        o_entry = '0;
        if (r_dir == DIR_PACK) begin
            o_entry.r0.data = p_tmp[DATA_W-1:0];
            o_entry.r0.last = i_tlast && !(p_e1 && p_flush);
            o_entry.r1.data = p_buf1[DATA_W-1:0];
            o_entry.r1.last = 1'b1;
            o_entry.cnt     = 2'(p_e1) + 2'(p_flush);
        end else begin
            o_entry.r0.data = {1'b0, u_tmp[SEPT_W-1:0]};
            o_entry.r0.last = (u_d1 == u_cnt9) || (u_short && !u_e2);
            o_entry.r0.shrt = u_short && !u_e2;
            o_entry.r1.data = {1'b0, u_tmp[2*SEPT_W-1:SEPT_W]};
            o_entry.r1.last = (u_d2 == u_cnt9) || u_short;
            o_entry.r1.shrt = u_short;
            o_entry.cnt     = u_act ? (u_e2 ? 2'd2 : 2'd1) : 2'd0;
        end
    end

    assign o_push = accept && (o_entry.cnt != 2'd0);

    always_comb begin
        n_dir   = r_dir;
        n_count = r_count;
        n_buf   = r_buf;
        n_held  = r_held;
        n_done  = r_done;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DIRECTION: begin
                    n_dir  = t_dir'(i_cfg_wdata[0]);
                    n_buf  = '0;
                    n_held = '0;
                    n_done = '0;
                end
                CFG_SEPTET_COUNT: begin
                    n_count = i_cfg_wdata;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end else if (accept) begin
            if (i_tlast) begin
                n_buf  = '0;
                n_held = '0;
                n_done = '0;
            end else if (r_dir == DIR_PACK) begin
                n_buf  = p_buf1;
                n_held = p_held1;
            end else if (u_act) begin
                n_buf  = u_e2 ? BUF_W'(u_tmp >> (2 * SEPT_W)) : BUF_W'(u_tmp >> SEPT_W);
                n_held = u_hsum - (u_e2 ? HELD_W'(2 * SEPT_W) : HELD_W'(SEPT_W));
                n_done = u_done_new[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_PACK;
            r_count <= '0;
            r_buf   <= '0;
            r_held  <= '0;
            r_done  <= '0;
        end else begin
            r_dir   <= n_dir;
            r_count <= n_count;
            r_buf   <= n_buf;
            r_held  <= n_held;
            r_done  <= n_done;
        end
    end

endmodule

// ----- hw/rtl/gsc_queue.sv -----
// ---------------------------------------------------------------------------
// gsc_queue
// short fifo of result entries between front and back
// ---------------------------------------------------------------------------
module gsc_queue
    import gsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_entry  i_entry,
    input  logic    i_pop,
    output t_entry  o_head,
    output t_q_stat o_stat
);

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, n_wp;
    logic [Q_AW-1:0]   r_rp, n_rp;
    logic [Q_AW:0]     r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_stat.full  = r_cnt == (Q_AW+1)'(Q_DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rp];

    always_comb begin
        n_wp  = do_push ? r_wp + Q_AW'(1) : r_wp;
        n_rp  = do_pop ? r_rp + Q_AW'(1) : r_rp;
        n_cnt = r_cnt + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/gsc_back.sv -----
// ---------------------------------------------------------------------------
// gsc_back
// unrolls queued entries into single results behind an output register
// ---------------------------------------------------------------------------
module gsc_back
    import gsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_entry            i_head,
    input  t_q_stat           i_q_stat,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic [DATA_W-1:0] o_tdata,
    output logic              o_tlast,
    output logic              o_tuser
);

    logic  r_valid, n_valid;
    logic  r_sel, n_sel;
    t_res  r_res;
    t_res  cur;
    logic  load;

    assign load  = (!r_valid || i_tready) && !i_q_stat.empty;
    assign cur   = r_sel ? i_head.r1 : i_head.r0;
    assign o_pop = load && (r_sel || (i_head.cnt != 2'd2));

    always_comb begin
        n_sel   = load ? !o_pop : r_sel;
        n_valid = load ? 1'b1 : (r_valid && !i_tready);
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_res.data;
    assign o_tlast  = r_res.last;
    assign o_tuser  = r_res.shrt;

endmodule
